>>> rtl/assert_macros.svh
// Assertion macros for the RTL file that carries concurrent checks (the top level).
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTHESIS
// Checks that a property holds at every rising clock edge outside reset.
`define ASSERT_AT(lbl, clk, rstn, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (prop)) else $error(msg);
// Checks that a condition is never true at a rising clock edge outside reset.
`define ASSERT_NEVER(lbl, clk, rstn, cond, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) !(cond)) else $error(msg);
`else
`define ASSERT_AT(lbl, clk, rstn, prop, msg)
`define ASSERT_NEVER(lbl, clk, rstn, cond, msg)
`endif
`endif

>>> rtl/mlsqm_pkg.sv
// Package of the list manager: field widths, command and status codes, control structs.
`default_nettype none

package mlsqm_pkg;

  // Fixed widths of the item fields.
  localparam int unsigned ACTION_W   = 2;
  localparam int unsigned LIST_NUM_W = 4;
  localparam int unsigned VALUE_W    = 32;
  localparam int unsigned STATUS_W   = 3;

  // Default sizes of the list table and node pool.
  localparam int unsigned LIST_COUNT_DEF = 16;
  localparam int unsigned POOL_DEPTH_DEF = 1024;
  localparam int unsigned DATA_WIDTH_DEF = 32;

  typedef logic [ACTION_W-1:0] action_t;
  typedef logic [STATUS_W-1:0] status_t;

  // Command codes.
  localparam action_t ACT_CREATE = 2'd0;
  localparam action_t ACT_PUSH   = 2'd1;
  localparam action_t ACT_POP    = 2'd2;
  localparam action_t ACT_NOP    = 2'd3;

  // Result status codes.
  localparam status_t ST_DONE    = 3'd0;
  localparam status_t ST_EXISTS  = 3'd1;
  localparam status_t ST_NO_LIST = 3'd2;
  localparam status_t ST_EMPTY   = 3'd3;
  localparam status_t ST_FULL    = 3'd4;

  // Conditions the datapath reports to the controller.
  typedef struct packed {
    action_t action;
    logic    in_range;
    logic    in_use;
    logic    empty;
    logic    is_queue;
    logic    have_recycled;
    logic    have_fresh;
    logic    out_free;
  } dp_sts_t;

  // Steps the controller orders from the datapath.
  typedef struct packed {
    logic    capture;
    logic    create;
    logic    push;
    logic    link;
    logic    pop_rd;
    logic    pop;
    logic    set_result;
    logic    load_out;
    status_t result;
  } dp_cmd_t;

endpackage

`default_nettype wire

>>> rtl/mlsqm_ram.sv
// Generic single-port-write, single-port-read RAM with registered read data.
`default_nettype none

module mlsqm_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 16,
  localparam int unsigned AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk_i,
  input  logic             we_i,
  input  logic [AW-1:0]    waddr_i,
  input  logic [WIDTH-1:0] wdata_i,
  input  logic             re_i,
  input  logic [AW-1:0]    raddr_i,
  output logic [WIDTH-1:0] rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  // Write port.
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
  end

  // Read port; the data holds while no read is requested.
  always_ff @(posedge clk_i) begin
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

`default_nettype wire

>>> rtl/mlsqm_ctrl.sv
// Controller state machine that sequences each command through the datapath.
`default_nettype none

module mlsqm_ctrl (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_valid_i,
  output logic              in_ready_o,
  input  mlsqm_pkg::dp_sts_t sts_i,
  output mlsqm_pkg::dp_cmd_t cmd_o
);
  import mlsqm_pkg::*;

  localparam logic [2:0] S_IDLE = 3'd0;
  localparam logic [2:0] S_LOOK = 3'd1;
  localparam logic [2:0] S_LINK = 3'd2;
  localparam logic [2:0] S_POP  = 3'd3;
  localparam logic [2:0] S_DONE = 3'd4;

  logic [2:0] state_q, state_d;

  // Next state and command decode.
  always_comb begin
    state_d    = state_q;
    cmd_o      = '0;
    in_ready_o = 1'b0;
    unique case (state_q)
      S_IDLE: begin
        in_ready_o = 1'b1;
        if (in_valid_i) begin
          cmd_o.capture = 1'b1;
          state_d       = S_LOOK;
        end
      end
      S_LOOK: begin
        cmd_o.set_result = 1'b1;
        cmd_o.result     = ST_DONE;
        state_d          = S_DONE;
        priority if (sts_i.action == ACT_NOP) begin
          cmd_o.result = ST_DONE;
        end else if (!sts_i.in_range) begin
          cmd_o.result = ST_NO_LIST;
        end else if (sts_i.action == ACT_CREATE) begin
          if (sts_i.in_use) begin
            cmd_o.result = ST_EXISTS;
          end else begin
            cmd_o.create = 1'b1;
          end
        end else if (!sts_i.in_use) begin
          cmd_o.result = ST_NO_LIST;
        end else if (sts_i.action == ACT_PUSH) begin
          if (!sts_i.have_recycled && !sts_i.have_fresh) begin
            cmd_o.result = ST_FULL;
          end else begin
            cmd_o.push = 1'b1;
            // A queue that already holds items also needs its old tail relinked.
            if (sts_i.is_queue && !sts_i.empty) begin
              state_d = S_LINK;
            end
          end
        end else begin
          if (sts_i.empty) begin
            cmd_o.result = ST_EMPTY;
          end else begin
            cmd_o.pop_rd = 1'b1;
            state_d      = S_POP;
          end
        end
      end
      S_LINK: begin
        cmd_o.link = 1'b1;
        state_d    = S_DONE;
      end
      S_POP: begin
        cmd_o.pop = 1'b1;
        state_d   = S_DONE;
      end
      S_DONE: begin
        if (sts_i.out_free) begin
          cmd_o.load_out = 1'b1;
          state_d        = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  // State register.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

endmodule

`default_nettype wire

>>> rtl/mlsqm_dp.sv
// Datapath: list table, node pool memories, free-node bookkeeping and the result registers.
`default_nettype none

module mlsqm_dp #(
  parameter int unsigned LIST_COUNT = mlsqm_pkg::LIST_COUNT_DEF,
  parameter int unsigned POOL_DEPTH = mlsqm_pkg::POOL_DEPTH_DEF,
  parameter int unsigned DATA_WIDTH = mlsqm_pkg::DATA_WIDTH_DEF
) (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  mlsqm_pkg::action_t                  action_i,
  input  logic [mlsqm_pkg::LIST_NUM_W-1:0]    list_number_i,
  input  logic                                list_kind_i,
  input  logic signed [mlsqm_pkg::VALUE_W-1:0] push_value_i,
  input  mlsqm_pkg::dp_cmd_t                  cmd_i,
  output mlsqm_pkg::dp_sts_t                  sts_o,
  input  logic                                out_ready_i,
  output logic                                out_valid_o,
  output mlsqm_pkg::status_t                  status_o,
  output logic signed [mlsqm_pkg::VALUE_W-1:0] pop_value_o,
  output logic                                value_valid_o
);
  import mlsqm_pkg::*;

  localparam int unsigned LW  = (LIST_COUNT > 1) ? $clog2(LIST_COUNT) : 1;
  localparam int unsigned PW  = $clog2(POOL_DEPTH);
  localparam int unsigned CW  = $clog2(POOL_DEPTH + 1);
  localparam int unsigned LEW = 1 + 2 * PW + CW;

  // Command fields held for the length of one item.
  action_t                 act_q;
  logic [LIST_NUM_W-1:0]   lnum_q;
  logic                    kind_q;
  logic [DATA_WIDTH-1:0]   pv_q;
  logic [PW-1:0]           node_q;
  logic [LW-1:0]           lidx;

  // Pool bookkeeping.
  logic [LIST_COUNT-1:0]   in_use_q, in_use_d;
  logic [PW-1:0]           rhead_q, rhead_d;
  logic [CW-1:0]           rcount_q, rcount_d;
  logic [CW-1:0]           fresh_q, fresh_d;

  // Result and output registers.
  status_t                 res_status_q;
  logic [DATA_WIDTH-1:0]   res_value_q;
  logic                    res_vv_q;
  logic                    out_valid_q;
  status_t                 out_status_q;
  logic [VALUE_W-1:0]      out_value_q;
  logic                    out_vv_q;

  // Memory ports.
  logic                    l_we;
  logic [LEW-1:0]          l_wdata, l_rdata;
  logic [PW-1:0]           k_waddr, k_raddr, k_wdata, k_rdata;
  logic                    k_we, k_re;
  logic [DATA_WIDTH-1:0]   v_rdata;

  // Decoded list entry and derived flags.
  logic                    ent_queue;
  logic [PW-1:0]           ent_head, ent_tail;
  logic [CW-1:0]           ent_count;
  logic                    empty, have_recycled, have_fresh;
  logic [PW-1:0]           alloc_n;
  logic [PW-1:0]           new_head, new_tail;

  assign lidx      = LW'(lnum_q);
  assign ent_queue = l_rdata[LEW-1];
  assign ent_head  = l_rdata[LEW-2 -: PW];
  assign ent_tail  = l_rdata[CW+PW-1 -: PW];
  assign ent_count = l_rdata[CW-1:0];

  assign empty         = (ent_count == '0);
  assign have_recycled = (rcount_q != '0);
  assign have_fresh    = (fresh_q < CW'(POOL_DEPTH));
  assign alloc_n       = have_recycled ? rhead_q : fresh_q[PW-1:0];

  // Capture the item fields when the item is taken, and the allocated node on a push.
  always_ff @(posedge clk_i) begin
    if (cmd_i.capture) begin
      act_q  <= action_i;
      lnum_q <= list_number_i;
      kind_q <= list_kind_i;
      pv_q   <= DATA_WIDTH'($unsigned(push_value_i));
    end
    if (cmd_i.push) begin
      node_q <= alloc_n;
    end
  end

  // Status toward the controller.
  always_comb begin
    sts_o.action        = act_q;
    sts_o.in_range      = (32'(lnum_q) < LIST_COUNT);
    sts_o.in_use        = in_use_q[lidx];
    sts_o.empty         = empty;
    sts_o.is_queue      = ent_queue;
    sts_o.have_recycled = have_recycled;
    sts_o.have_fresh    = have_fresh;
    sts_o.out_free      = !out_valid_q || out_ready_i;
  end

  // Head and tail after a push: stacks grow at the head, queues at the tail.
  assign new_head = (empty || !ent_queue) ? alloc_n : ent_head;
  assign new_tail = (empty || ent_queue) ? alloc_n : ent_tail;

  // List table write data.
  always_comb begin
    l_we    = 1'b0;
    l_wdata = l_rdata;
    priority if (cmd_i.create) begin
      l_we    = 1'b1;
      l_wdata = {kind_q, {PW{1'b0}}, {PW{1'b0}}, {CW{1'b0}}};
    end else if (cmd_i.push) begin
      l_we    = 1'b1;
      l_wdata = {ent_queue, new_head, new_tail, ent_count + CW'(1)};
    end else if (cmd_i.pop) begin
      l_we = 1'b1;
      if (ent_count == CW'(1)) begin
        l_wdata = {ent_queue, {PW{1'b0}}, {PW{1'b0}}, ent_count - CW'(1)};
      end else begin
        l_wdata = {ent_queue, k_rdata, ent_tail, ent_count - CW'(1)};
      end
    end else begin
      l_we = 1'b0;
    end
  end

  // Link memory port selection.
  always_comb begin
    k_we    = 1'b0;
    k_waddr = alloc_n;
    k_wdata = '0;
    priority if (cmd_i.push) begin
      k_we    = 1'b1;
      k_waddr = alloc_n;
      k_wdata = (empty || ent_queue) ? '0 : ent_head;
    end else if (cmd_i.link) begin
      k_we    = 1'b1;
      k_waddr = ent_tail;
      k_wdata = node_q;
    end else if (cmd_i.pop) begin
      k_we    = 1'b1;
      k_waddr = ent_head;
      k_wdata = rhead_q;
    end else begin
      k_we = 1'b0;
    end
  end

  assign k_re    = cmd_i.capture || cmd_i.pop_rd;
  assign k_raddr = cmd_i.capture ? rhead_q : ent_head;

  // Free-node bookkeeping and list in-use flags: recycled nodes are reused before fresh ones.
  always_comb begin
    in_use_d = in_use_q;
    rhead_d  = rhead_q;
    rcount_d = rcount_q;
    fresh_d  = fresh_q;
    if (cmd_i.create) begin
      in_use_d[lidx] = 1'b1;
    end
    if (cmd_i.push) begin
      if (have_recycled) begin
        rhead_d  = k_rdata;
        rcount_d = rcount_q - CW'(1);
      end else begin
        fresh_d = fresh_q + CW'(1);
      end
    end
    if (cmd_i.pop) begin
      rhead_d  = ent_head;
      rcount_d = rcount_q + CW'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_use_q <= '0;
      rhead_q  <= '0;
      rcount_q <= '0;
      fresh_q  <= '0;
    end else begin
      in_use_q <= in_use_d;
      rhead_q  <= rhead_d;
      rcount_q <= rcount_d;
      fresh_q  <= fresh_d;
    end
  end

  // Result of the item under way.
  always_ff @(posedge clk_i) begin
    if (cmd_i.set_result) begin
      res_status_q <= cmd_i.result;
      res_value_q  <= '0;
      res_vv_q     <= 1'b0;
    end else if (cmd_i.pop) begin
      res_value_q <= v_rdata;
      res_vv_q    <= 1'b1;
    end
  end

  // Output register, loaded once the previous item has been taken.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (cmd_i.load_out) begin
      out_valid_q <= 1'b1;
    end else if (out_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.load_out) begin
      out_status_q <= res_status_q;
      out_value_q  <= VALUE_W'(res_value_q);
      out_vv_q     <= res_vv_q;
    end
  end

  assign out_valid_o   = out_valid_q;
  assign status_o      = out_status_q;
  assign pop_value_o   = $signed(out_value_q);
  assign value_valid_o = out_vv_q;

  // Per-list table: queue flag, head, tail and entry count.
  mlsqm_ram #(
    .WIDTH (LEW),
    .DEPTH (LIST_COUNT)
  ) u_list_ram (
    .clk_i   (clk_i),
    .we_i    (l_we),
    .waddr_i (lidx),
    .wdata_i (l_wdata),
    .re_i    (cmd_i.capture),
    .raddr_i (LW'(list_number_i)),
    .rdata_o (l_rdata)
  );

  // Node data words.
  mlsqm_ram #(
    .WIDTH (DATA_WIDTH),
    .DEPTH (POOL_DEPTH)
  ) u_value_ram (
    .clk_i   (clk_i),
    .we_i    (cmd_i.push),
    .waddr_i (alloc_n),
    .wdata_i (pv_q),
    .re_i    (cmd_i.pop_rd),
    .raddr_i (ent_head),
    .rdata_o (v_rdata)
  );

  // Node links, shared by the lists and the recycled chain.
  mlsqm_ram #(
    .WIDTH (PW),
    .DEPTH (POOL_DEPTH)
  ) u_link_ram (
    .clk_i   (clk_i),
    .we_i    (k_we),
    .waddr_i (k_waddr),
    .wdata_i (k_wdata),
    .re_i    (k_re),
    .raddr_i (k_raddr),
    .rdata_o (k_rdata)
  );

endmodule

`default_nettype wire

>>> rtl/multi_list_stack_queue_manager.sv
// Top level of the multi-list stack and queue manager over a shared node pool.
//
// Channel   Direction  Handshake                 Payload
// in        input      in_valid_i / in_ready_o   action_i, list_number_i, list_kind_i,
//                                                push_value_i
// out       output     out_valid_o / out_ready_i status_o, pop_value_o, value_valid_o
//
// One item is in work at a time. Each item passes through a look-up step and a done step
// before the next acceptance; a successful pop or a push onto a non-empty queue also takes
// a pop or link step between them, set by the accesses of the list table and node link
// memory, each with one registered read port. A finished result waits in the output
// register, and the sequencer holds in its last step while that register is still full.
// After reset all lists are absent and the pool is empty; no clearing pass is needed.
`default_nettype none
`include "assert_macros.svh"

module multi_list_stack_queue_manager #(
  parameter int unsigned LIST_COUNT = mlsqm_pkg::LIST_COUNT_DEF,
  parameter int unsigned POOL_DEPTH = mlsqm_pkg::POOL_DEPTH_DEF,
  parameter int unsigned DATA_WIDTH = mlsqm_pkg::DATA_WIDTH_DEF
) (
  input  logic                                 clk_i,
  input  logic                                 rst_ni,
  input  logic                                 in_valid_i,
  output logic                                 in_ready_o,
  input  mlsqm_pkg::action_t                   action_i,
  input  logic [mlsqm_pkg::LIST_NUM_W-1:0]     list_number_i,
  input  logic                                 list_kind_i,
  input  logic signed [mlsqm_pkg::VALUE_W-1:0] push_value_i,
  output logic                                 out_valid_o,
  input  logic                                 out_ready_i,
  output mlsqm_pkg::status_t                   status_o,
  output logic signed [mlsqm_pkg::VALUE_W-1:0] pop_value_o,
  output logic                                 value_valid_o
);
  import mlsqm_pkg::*;

  dp_cmd_t cmd;
  dp_sts_t sts;

  // Sequencer.
  mlsqm_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_ready_o (in_ready_o),
    .sts_i      (sts),
    .cmd_o      (cmd)
  );

  // Storage and result path.
  mlsqm_dp #(
    .LIST_COUNT (LIST_COUNT),
    .POOL_DEPTH (POOL_DEPTH),
    .DATA_WIDTH (DATA_WIDTH)
  ) u_dp (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .action_i      (action_i),
    .list_number_i (list_number_i),
    .list_kind_i   (list_kind_i),
    .push_value_i  (push_value_i),
    .cmd_i         (cmd),
    .sts_o         (sts),
    .out_ready_i   (out_ready_i),
    .out_valid_o   (out_valid_o),
    .status_o      (status_o),
    .pop_value_o   (pop_value_o),
    .value_valid_o (value_valid_o)
  );

  // Checks on the sequencing between controller and datapath.
  `ASSERT_AT(a_busy_after_accept, clk_i, rst_ni, in_valid_i && in_ready_o |=> !in_ready_o, "item accepted while another is in work")
  `ASSERT_AT(a_pop_after_read, clk_i, rst_ni, cmd.pop |-> $past(cmd.pop_rd), "pop completed without a node read")
  `ASSERT_AT(a_one_update, clk_i, rst_ni, $onehot0({cmd.create, cmd.push, cmd.link, cmd.pop}), "two list updates in one cycle")
  `ASSERT_NEVER(a_no_overwrite, clk_i, rst_ni, cmd.load_out && out_valid_o && !out_ready_i, "result overwrites one not yet taken")

endmodule

`default_nettype wire
